### rtl/sxt_pkg.sv
package sxt_pkg;

	// default configuration
	localparam int OFFSET_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// most tokens one byte can cause
	localparam int MAX_TOKENS = 3;

	// character codes
	localparam logic [7:0] CH_SEMI      = 8'h3B;
	localparam logic [7:0] CH_BAR       = 8'h7C;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_QUOTE     = 8'h27;
	localparam logic [7:0] CH_BACKQUOTE = 8'h60;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_VT        = 8'h0B;
	localparam logic [7:0] CH_FF        = 8'h0C;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_UPPER_E   = 8'h45;
	localparam logic [7:0] CH_LOWER_E   = 8'h65;
	localparam logic [7:0] CH_UPPER_D   = 8'h44;
	localparam logic [7:0] CH_LOWER_D   = 8'h64;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_COMMENT,
		MODE_NUMBER,
		MODE_STRING,
		MODE_BARSYM,
		MODE_SYMBOL,
		MODE_ESCAPE,
		MODE_SYMBAR
	} mode_t;

	typedef enum logic [2:0] {
		KIND_END,
		KIND_SYMBOL,
		KIND_KEYWORD,
		KIND_NUMBER,
		KIND_STRING,
		KIND_OPEN,
		KIND_CLOSE,
		KIND_ERROR
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
	} tok_t;

	// all tokens caused by one byte, oldest in slot 0
	typedef struct packed {
		logic [1:0]                 count;
		tok_t [MAX_TOKENS-1:0]      tok;
	} bundle_t;

	function automatic logic is_space(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT ||
			b == CH_FF || b == CH_CR;
	endfunction

	function automatic logic is_num_start(input logic [7:0] b);
		return b == CH_PLUS || b == CH_MINUS || (b >= CH_ZERO && b <= CH_NINE);
	endfunction

	function automatic logic is_num_char(input logic [7:0] b);
		return is_num_start(b) || b == CH_DOT || b == CH_UPPER_E || b == CH_LOWER_E ||
			b == CH_UPPER_D || b == CH_LOWER_D;
	endfunction

	function automatic logic is_sym_end(input logic [7:0] b);
		return b == CH_SPACE || b == CH_LF || b == CH_TAB || b == CH_LPAREN ||
			b == CH_RPAREN || b == CH_COMMA || b == CH_QUOTE || b == CH_BACKQUOTE;
	endfunction

endpackage

### rtl/sxt_front.sv
module sxt_front #(
	parameter int OFFSET_BITS = sxt_pkg::OFFSET_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       byte_in,
	input  logic             last_byte,
	input  logic             q_full,
	output logic             bnd_push,
	output sxt_pkg::bundle_t bnd
);
	import sxt_pkg::*;

	localparam int OW = OFFSET_BITS;
	localparam int EW = (OW > 16) ? OW : 16;

	mode_t         mode_q, mode_d;
	logic          kw_q, kw_d;
	logic [OW-1:0] beg_q, beg_d;
	logic [OW-1:0] pos_q, pos_d;
	logic          halt_q, halt_d;

	logic          accept;
	logic [OW-1:0] past;

	// candidate tokens in emission order
	tok_t [3:0]    cand;
	logic [3:0]    cand_v;
	kind_t         a_kind, b_kind, c_kind;
	logic [1:0]    n;
	tok_t [MAX_TOKENS-1:0] slots;
	logic          idle_go;

	function automatic logic [15:0] clamp16(input logic [OW-1:0] v);
		logic [EW-1:0] e;
		e = EW'(v);
		return (e > EW'(16'hFFFF)) ? 16'hFFFF : e[15:0];
	endfunction

	function automatic tok_t mk_tok(input kind_t k, input logic [OW-1:0] s,
			input logic [OW-1:0] e);
		logic [OW-1:0] len;
		tok_t t;
		len = (e > s) ? e - s : '0;
		t.kind = k;
		t.start = clamp16(s);
		t.length = clamp16(len);
		return t;
	endfunction

	assign accept = push && !q_full;
	assign full = q_full;
	assign past = (pos_q == '1) ? pos_q : pos_q + OW'(1);

	// lexer next state and tokens
	always_comb begin
		mode_d = mode_q;
		kw_d = kw_q;
		beg_d = beg_q;
		halt_d = halt_q;
		pos_d = past;
		cand_v = '0;
		a_kind = KIND_SYMBOL;
		b_kind = KIND_OPEN;
		c_kind = KIND_SYMBOL;
		idle_go = 1'b0;

		if (!halt_q) begin
			unique case (mode_q)
				MODE_COMMENT: begin
					if (byte_in == CH_LF)
						mode_d = MODE_IDLE;
				end
				MODE_STRING: begin
					if (byte_in == CH_DQUOTE) begin
						cand_v[0] = 1'b1;
						a_kind = KIND_STRING;
						mode_d = MODE_IDLE;
					end
				end
				MODE_BARSYM: begin
					if (byte_in == CH_BAR) begin
						cand_v[0] = 1'b1;
						a_kind = KIND_SYMBOL;
						mode_d = MODE_IDLE;
					end
				end
				MODE_NUMBER: begin
					if (!is_num_char(byte_in)) begin
						cand_v[0] = 1'b1;
						a_kind = KIND_NUMBER;
						mode_d = MODE_IDLE;
						idle_go = 1'b1;
					end
				end
				MODE_SYMBOL: begin
					if (is_sym_end(byte_in)) begin
						cand_v[0] = 1'b1;
						a_kind = kw_q ? KIND_KEYWORD : KIND_SYMBOL;
						mode_d = MODE_IDLE;
						idle_go = 1'b1;
					end else if (byte_in == CH_BACKSLASH) begin
						mode_d = MODE_ESCAPE;
					end else if (byte_in == CH_BAR) begin
						mode_d = MODE_SYMBAR;
					end
				end
				MODE_ESCAPE: begin
					mode_d = MODE_SYMBOL;
				end
				MODE_SYMBAR: begin
					if (byte_in == CH_BAR)
						mode_d = MODE_SYMBOL;
				end
				MODE_IDLE: begin
					idle_go = 1'b1;
				end
			endcase
		end

		// start of a new token, or punctuation
		if (idle_go && !(is_space(byte_in) || byte_in == CH_QUOTE ||
				byte_in == CH_BACKQUOTE)) begin
			beg_d = pos_q;
			kw_d = 1'b0;
			priority if (byte_in == CH_SEMI) begin
				mode_d = MODE_COMMENT;
			end else if (byte_in == CH_LPAREN) begin
				cand_v[1] = 1'b1;
				b_kind = KIND_OPEN;
			end else if (byte_in == CH_RPAREN) begin
				cand_v[1] = 1'b1;
				b_kind = KIND_CLOSE;
			end else if (is_num_start(byte_in)) begin
				mode_d = MODE_NUMBER;
			end else if (byte_in == CH_DQUOTE) begin
				beg_d = past;
				mode_d = MODE_STRING;
			end else if (byte_in == CH_BAR) begin
				beg_d = past;
				mode_d = MODE_BARSYM;
			end else if (byte_in == CH_COMMA) begin
				cand_v[1] = 1'b1;
				b_kind = KIND_ERROR;
				halt_d = 1'b1;
			end else if (byte_in == CH_COLON) begin
				kw_d = 1'b1;
				mode_d = MODE_SYMBOL;
			end else if (byte_in == CH_BACKSLASH) begin
				mode_d = MODE_ESCAPE;
			end else begin
				mode_d = MODE_SYMBOL;
			end
		end

		// end of stream: flush the open token, then the end marker
		if (last_byte) begin
			if (!halt_d) begin
				unique case (mode_d)
					MODE_NUMBER: begin
						cand_v[2] = 1'b1;
						c_kind = KIND_NUMBER;
					end
					MODE_SYMBOL, MODE_ESCAPE, MODE_SYMBAR: begin
						cand_v[2] = 1'b1;
						c_kind = kw_d ? KIND_KEYWORD : KIND_SYMBOL;
					end
					MODE_STRING, MODE_BARSYM: begin
						cand_v[2] = 1'b1;
						c_kind = KIND_ERROR;
					end
					MODE_IDLE, MODE_COMMENT: begin
						cand_v[2] = 1'b0;
					end
				endcase
			end
			cand_v[3] = 1'b1;
			cand[2] = mk_tok(c_kind, beg_d, past);
			mode_d = MODE_IDLE;
			kw_d = 1'b0;
			beg_d = '0;
			pos_d = '0;
			halt_d = 1'b0;
		end else begin
			cand[2] = mk_tok(c_kind, beg_d, past);
		end

		cand[0] = mk_tok(a_kind, beg_q, pos_q);
		cand[1] = mk_tok(b_kind, pos_q, pos_q);
		cand[3] = mk_tok(KIND_END, past, past);

		// pack valid candidates into the bundle
		n = 2'd0;
		slots = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i] && n != 2'd3) begin
				slots[n] = cand[i];
				n = n + 2'd1;
			end
		end
	end

	assign bnd.count = n;
	assign bnd.tok = slots;
	assign bnd_push = accept && (n != 2'd0);

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			kw_q <= 1'b0;
			beg_q <= '0;
			pos_q <= '0;
			halt_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			kw_q <= kw_d;
			beg_q <= beg_d;
			pos_q <= pos_d;
			halt_q <= halt_d;
		end
	end

	// after a comma the lexer sits idle until the stream ends
	a_halt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |-> mode_q == MODE_IDLE)
		else $error("halted lexer left idle mode");

	// the final byte always closes the stream with an end token
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |-> (bnd_push && bnd.tok[bnd.count - 2'd1].kind == KIND_END))
		else $error("final byte without end token");

endmodule

### rtl/sxt_fifo.sv
module sxt_fifo #(
	parameter int DEPTH = sxt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  sxt_pkg::bundle_t wr_data,
	output logic             q_full,
	input  logic             rd_en,
	output sxt_pkg::bundle_t rd_data,
	output logic             q_empty
);
	import sxt_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t       mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign q_full = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr = wr_en && !q_full;
	assign do_rd = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	// bundle storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

### rtl/sxt_back.sv
module sxt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  sxt_pkg::bundle_t head,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output logic [2:0]       token_kind,
	output logic [15:0]      text_start,
	output logic [15:0]      text_length,
	output logic             last_of_run
);
	import sxt_pkg::*;

	logic [1:0] idx_q;
	logic       is_last;
	logic       xfer;
	tok_t       cur;

	assign empty = q_empty;
	assign xfer = pop && !q_empty;
	assign cur = head.tok[idx_q];
	assign is_last = (idx_q == head.count - 2'd1);
	assign q_pop = xfer && is_last;

	assign token_kind = cur.kind;
	assign text_start = cur.start;
	assign text_length = cur.length;
	assign last_of_run = is_last;

	// walk through the tokens of the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (xfer) begin
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	// slot index stays inside the bundle
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (idx_q < head.count))
		else $error("token index past bundle count");

	// index rests at zero while nothing waits
	a_idx_rest: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> idx_q == 2'd0)
		else $error("token index not reset with queue empty");

endmodule

### rtl/sexpr_tokenizer_top.sv
// S-expression lexer. Bytes go in on the push/full side, one per transfer,
// with last_byte marking the final byte of a stream; tokens come out on the
// empty/pop side as kind, start offset and length, with last_of_run set on
// the final token a byte caused. A byte is taken every cycle while full is
// low and is classified in that same cycle; each byte yields zero to three
// tokens, which wait in a queue of QUEUE_DEPTH bundles and drain at one token
// per pop. The sustained rate is one byte per cycle as long as bytes average
// at most one token, and is otherwise set by the single-token output port.
// Offsets count in OFFSET_BITS bits and saturate; the reported start and
// length saturate at 65535. After a comma the stream yields only its end.
module sexpr_tokenizer_top #(
	parameter int OFFSET_BITS = sxt_pkg::OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH = sxt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  byte_in,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  token_kind,
	output logic [15:0] text_start,
	output logic [15:0] text_length,
	output logic        last_of_run
);
	import sxt_pkg::*;

	logic    bnd_push, q_full, q_empty, q_pop;
	bundle_t bnd, head;

	// byte classification and lexer state
	sxt_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.byte_in  (byte_in),
		.last_byte(last_byte),
		.q_full   (q_full),
		.bnd_push (bnd_push),
		.bnd      (bnd)
	);

	// token bundles between the two sides
	sxt_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (bnd_push),
		.wr_data(bnd),
		.q_full (q_full),
		.rd_en  (q_pop),
		.rd_data(head),
		.q_empty(q_empty)
	);

	// one token per output transfer
	sxt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (head),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.token_kind (token_kind),
		.text_start (text_start),
		.text_length(text_length),
		.last_of_run(last_of_run)
	);

endmodule
